// ===== rtl/erps_pkg.sv =====
// Shared constants, ring table entry type and small arithmetic helpers for the
// expanding ring pixel shader. No dependencies; used by the top level and its checker.
package erps_pkg;

  localparam int SLOTS = 10;
  localparam int ROWS  = 25;
  localparam int FOLDS = 5;

  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int FOLD_W  = (FOLDS > 1) ? $clog2(FOLDS) : 1;
  localparam int COORD_W = 7;
  localparam int ROW_W   = 5;
  localparam int RAD_W   = 12;
  localparam int COLOR_W = 8;
  // unfolded row reaches (2^ROW_W - 1) + (FOLDS - 1) * ROWS
  localparam int UROW_W  = $clog2((1 << ROW_W) + (FOLDS - 1) * ROWS);
  localparam int D_W     = 2 * UROW_W + 1;
  localparam int BAND_W  = 26;

  localparam int S_TDATA_W = 56;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;

  localparam logic [RAD_W-1:0]   RADIUS_MAX = {RAD_W{1'b1}};
  localparam logic [COLOR_W-1:0] COLOR_MAX  = {COLOR_W{1'b1}};
  localparam logic [RAD_W-1:0]   BAND_SPLIT = RAD_W'(6);

  // floor(c * 49 / 50) == (c * 49 * 5243) >> 18 for every 8-bit c
  localparam logic [25:0] FADE_MUL   = 26'd256907;
  localparam int          FADE_SHIFT = 18;
  // floor(r / 6) == (r * 43691) >> 18 for every 12-bit r
  localparam logic [29:0] DIV6_MUL   = 30'd43691;
  localparam int          DIV6_SHIFT = 18;

  localparam logic [1:0] OP_SPAWN   = 2'd0;
  localparam logic [1:0] OP_ADVANCE = 2'd1;
  localparam logic [1:0] OP_SHADE   = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [RAD_W-1:0]   radius;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [BAND_W-1:0]  lo;
    logic [BAND_W-1:0]  hi;
  } ring_t;

  function automatic logic [COLOR_W-1:0] fade(input logic [COLOR_W-1:0] c);
    logic [25:0] p;
    p = 26'(c) * FADE_MUL;
    return p[FADE_SHIFT +: COLOR_W];
  endfunction

  function automatic logic [RAD_W-1:0] div6(input logic [RAD_W-1:0] r);
    logic [29:0] p;
    p = 30'(r) * DIV6_MUL;
    return p[DIV6_SHIFT +: RAD_W];
  endfunction

  function automatic logic [COLOR_W-1:0] sat_add(input logic [COLOR_W-1:0] a,
                                                 input logic [COLOR_W-1:0] b);
    logic [COLOR_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COLOR_W] ? COLOR_MAX : s[COLOR_W-1:0];
  endfunction

endpackage

// ===== rtl/expanding_ring_pixel_shader.sv =====
// Expanding ring pixel shader: ring table in one synchronous memory, a sequencer
// that spawns, advances and shades. Depends on erps_pkg.
//
// A spawn beat writes its ring in its accept cycle. An advance beat's accept cycle issues the
// first read; then each active ring is read and written back with the grown radius,
// faded colour and its precomputed band. A shade beat tests one (ring, fold) pair per
// cycle off the memory read port, all FOLDS folds of each active ring in turn, after the
// accept cycle that issues the first read, and then loads the result into the output
// register once it is free. The result then sits in that register; spawn and
// advance beats are still taken while it waits.
module expanding_ring_pixel_shader (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // spawn_x, spawn_y, spawn_red, spawn_green, spawn_blue, pixel_column,
  // pixel_row, zero pad
  input  logic [erps_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [erps_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_red, out_green, out_blue
  output logic [erps_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_ADV_LOAD  = 3'd1;
  localparam logic [2:0] ST_ADV_WRITE = 3'd2;
  localparam logic [2:0] ST_SH_FOLD   = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;

  logic [2:0] state;

  // input fields
  logic [erps_pkg::COORD_W-1:0] in_spawn_x, in_spawn_y, in_col;
  logic [erps_pkg::COLOR_W-1:0] in_red, in_green, in_blue;
  logic [erps_pkg::ROW_W-1:0]   in_row;
  logic [1:0]                   in_op;

  assign in_spawn_x = s_axis_tdata[6:0];
  assign in_spawn_y = s_axis_tdata[13:7];
  assign in_red     = s_axis_tdata[21:14];
  assign in_green   = s_axis_tdata[29:22];
  assign in_blue    = s_axis_tdata[37:30];
  assign in_col     = s_axis_tdata[44:38];
  assign in_row     = s_axis_tdata[49:45];
  assign in_op      = s_axis_tuser[1:0];

  logic in_fire;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // ring table
  erps_pkg::ring_t ring_mem [erps_pkg::SLOTS];
  erps_pkg::ring_t mem_q, mem_wdata;
  logic                        mem_we, mem_re;
  logic [erps_pkg::SLOT_W-1:0] mem_waddr, mem_raddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= ring_mem[mem_raddr];
    end
  end

  logic [erps_pkg::SLOT_W-1:0]  next_slot, slot;
  logic [erps_pkg::CNT_W-1:0]   active_count;
  logic [erps_pkg::FOLD_W-1:0]  fold;
  logic [erps_pkg::UROW_W-1:0]  urow;
  logic [erps_pkg::COORD_W-1:0] sh_col;
  logic [erps_pkg::ROW_W-1:0]   sh_row;
  logic [erps_pkg::COLOR_W-1:0] acc_red, acc_green, acc_blue;

  // advance working registers
  logic [erps_pkg::RAD_W-1:0]   adv_radius, adv_q6;
  logic [erps_pkg::COLOR_W-1:0] adv_red, adv_green, adv_blue;

  logic last_slot, last_fold;
  assign last_slot = (erps_pkg::CNT_W'(slot) + erps_pkg::CNT_W'(1)) >= active_count;
  assign last_fold = (fold == erps_pkg::FOLD_W'(erps_pkg::FOLDS - 1));

  // band of the grown radius
  logic [erps_pkg::RAD_W:0]    band_a, band_b, band_sel;
  logic [erps_pkg::BAND_W-1:0] band_lo, band_hi;
  logic                        band_small;

  always_comb begin
    band_small = adv_radius < erps_pkg::BAND_SPLIT;
    band_a     = {1'b0, adv_radius} - {1'b0, adv_q6};
    band_b     = {1'b0, adv_radius} + {1'b0, adv_q6};
    band_sel   = band_small ? {1'b0, adv_radius} : band_b;
    band_hi    = erps_pkg::BAND_W'(band_sel) * erps_pkg::BAND_W'(band_sel);
    band_lo    = band_small ? '0 : erps_pkg::BAND_W'(band_a) * erps_pkg::BAND_W'(band_a);
  end

  // hit test of the current ring at the current unfolded row
  logic [erps_pkg::COORD_W-1:0]  dx;
  logic [erps_pkg::UROW_W-1:0]   dy, cy_ext;
  logic [2*erps_pkg::COORD_W-1:0] dx2;
  logic [2*erps_pkg::UROW_W-1:0]  dy2;
  logic [erps_pkg::D_W-1:0]       sq_dist;
  logic                           hit;

  always_comb begin
    cy_ext  = erps_pkg::UROW_W'(mem_q.cy);
    dx      = (mem_q.cx > sh_col) ? mem_q.cx - sh_col : sh_col - mem_q.cx;
    dy      = (cy_ext > urow) ? cy_ext - urow : urow - cy_ext;
    dx2     = (2*erps_pkg::COORD_W)'(dx) * (2*erps_pkg::COORD_W)'(dx);
    dy2     = (2*erps_pkg::UROW_W)'(dy) * (2*erps_pkg::UROW_W)'(dy);
    sq_dist = erps_pkg::D_W'(dx2) + erps_pkg::D_W'(dy2);
    hit     = (erps_pkg::BAND_W'(sq_dist) >= mem_q.lo) &&
              (erps_pkg::BAND_W'(sq_dist) <= mem_q.hi);
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = next_slot;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && in_op == erps_pkg::OP_SPAWN) begin
          mem_we           = 1'b1;
          mem_wdata.cx     = in_spawn_x;
          mem_wdata.cy     = in_spawn_y;
          mem_wdata.red    = in_red;
          mem_wdata.green  = in_green;
          mem_wdata.blue   = in_blue;
        end
        if (in_fire && active_count != '0 &&
            (in_op == erps_pkg::OP_ADVANCE || in_op == erps_pkg::OP_SHADE)) begin
          mem_re = 1'b1;
        end
      end
      ST_ADV_WRITE: begin
        mem_we           = 1'b1;
        mem_waddr        = slot;
        mem_wdata.cx     = mem_q.cx;
        mem_wdata.cy     = mem_q.cy;
        mem_wdata.radius = adv_radius;
        mem_wdata.red    = adv_red;
        mem_wdata.green  = adv_green;
        mem_wdata.blue   = adv_blue;
        mem_wdata.lo     = band_lo;
        mem_wdata.hi     = band_hi;
        mem_re           = !last_slot;
        mem_raddr        = slot + erps_pkg::SLOT_W'(1);
      end
      ST_SH_FOLD: begin
        mem_re    = last_fold && !last_slot;
        mem_raddr = slot + erps_pkg::SLOT_W'(1);
      end
      ST_ADV_LOAD, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      next_slot    <= '0;
      active_count <= '0;
      slot         <= '0;
      fold         <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          slot <= '0;
          fold <= '0;
          if (in_fire) begin
            unique case (in_op)
              erps_pkg::OP_SPAWN: begin
                next_slot <= (next_slot == erps_pkg::SLOT_W'(erps_pkg::SLOTS - 1)) ?
                             '0 : next_slot + erps_pkg::SLOT_W'(1);
                if (active_count != erps_pkg::CNT_W'(erps_pkg::SLOTS)) begin
                  active_count <= active_count + erps_pkg::CNT_W'(1);
                end
              end
              erps_pkg::OP_ADVANCE: begin
                if (active_count != '0) begin
                  state <= ST_ADV_LOAD;
                end
              end
              erps_pkg::OP_SHADE: begin
                state <= (active_count != '0) ? ST_SH_FOLD : ST_DONE;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADV_LOAD: begin
          state <= ST_ADV_WRITE;
        end
        ST_ADV_WRITE: begin
          slot  <= slot + erps_pkg::SLOT_W'(1);
          state <= last_slot ? ST_IDLE : ST_ADV_LOAD;
        end
        ST_SH_FOLD: begin
          if (last_fold) begin
            fold <= '0;
            slot <= slot + erps_pkg::SLOT_W'(1);
            if (last_slot) begin
              state <= ST_DONE;
            end
          end else begin
            fold <= fold + erps_pkg::FOLD_W'(1);
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      sh_col    <= in_col;
      sh_row    <= in_row;
      urow      <= erps_pkg::UROW_W'(in_row);
      acc_red   <= '0;
      acc_green <= '0;
      acc_blue  <= '0;
    end
    if (state == ST_ADV_LOAD) begin
      adv_radius <= (mem_q.radius == erps_pkg::RADIUS_MAX) ?
                    mem_q.radius : mem_q.radius + erps_pkg::RAD_W'(1);
      adv_q6     <= erps_pkg::div6((mem_q.radius == erps_pkg::RADIUS_MAX) ?
                    mem_q.radius : mem_q.radius + erps_pkg::RAD_W'(1));
      adv_red    <= erps_pkg::fade(mem_q.red);
      adv_green  <= erps_pkg::fade(mem_q.green);
      adv_blue   <= erps_pkg::fade(mem_q.blue);
    end
    if (state == ST_SH_FOLD) begin
      // restart the unfolded row at each new ring
      urow <= last_fold ? erps_pkg::UROW_W'(sh_row) :
              urow + erps_pkg::UROW_W'(erps_pkg::ROWS);
      if (hit) begin
        acc_red   <= erps_pkg::sat_add(acc_red, mem_q.red);
        acc_green <= erps_pkg::sat_add(acc_green, mem_q.green);
        acc_blue  <= erps_pkg::sat_add(acc_blue, mem_q.blue);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {acc_blue, acc_green, acc_red};
    end
  end

endmodule

// ===== rtl/erps_checker.sv =====
// Port-level checker for the expanding ring pixel shader, bound to the top level.
// Depends on erps_pkg for the op codes.
module erps_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [erps_pkg::S_TUSER_W-1:0] s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [erps_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic in_beat;
  assign in_beat = s_axis_tvalid && s_axis_tready;

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

  // a shade beat keeps the input side busy in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    in_beat && s_axis_tuser[1:0] == erps_pkg::OP_SHADE |=> !s_axis_tready)
    else $error("input taken during shade");

  // after a spawn beat the input side is ready again in the following cycle
  assert property (@(posedge clk) disable iff (rst)
    in_beat && s_axis_tuser[1:0] == erps_pkg::OP_SPAWN |=> s_axis_tready)
    else $error("spawn did not finish in one cycle");

  // only a shade beat produces a result
  assert property (@(posedge clk) disable iff (rst)
    in_beat && s_axis_tuser[1:0] != erps_pkg::OP_SHADE |=> !$rose(m_axis_tvalid))
    else $error("result without a shade beat");

endmodule

bind expanding_ring_pixel_shader erps_checker u_erps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/expanding_ring_pixel_shader_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the expanding ring pixel shader: streams spawn, advance and
// shade beats, keeps its own ring table and checks every shaded pixel in order.
// Depends on erps_pkg and expanding_ring_pixel_shader.
module expanding_ring_pixel_shader_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RESULT_WAIT    = 20_000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_ITEMS    = 450;
  localparam int IDLE_PCT[4]    = '{0, 84, 0, 18};
  localparam int STALL_PCT[4]   = '{0, 0, 84, 18};

  typedef struct packed {
    logic [1:0]                     op;
    logic [erps_pkg::S_TDATA_W-1:0] data;
  } beat_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // spawn_x, spawn_y, spawn_red, spawn_green, spawn_blue, pixel_column, pixel_row, zero pad
  logic [erps_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  // op
  logic [erps_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // out_red, out_green, out_blue
  logic [erps_pkg::M_TDATA_W-1:0] m_axis_tdata;

  expanding_ring_pixel_shader dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  beat_t                          pending_beats[$];
  logic [erps_pkg::M_TDATA_W-1:0] expected_rgb_q[$];
  int                             mismatch_count = 0;
  int                             pixels_seen = 0;
  int                             idle_pct = 0;
  int                             stall_pct = 0;
  logic                           hold_go = 1'b0;
  logic                           hold_used = 1'b0;
  int                             hold_left = 0;
  int unsigned                    cycle_count = 0;
  beat_t                          next_beat;
  logic [erps_pkg::M_TDATA_W-1:0] pixel_want;
  string                          chan_name[3] = '{"red", "green", "blue"};

  // ring table as the block should hold it
  int unsigned ring_x[erps_pkg::SLOTS], ring_y[erps_pkg::SLOTS], ring_rad[erps_pkg::SLOTS];
  int unsigned ring_r[erps_pkg::SLOTS], ring_g[erps_pkg::SLOTS], ring_b[erps_pkg::SLOTS];
  int unsigned write_slot = 0;
  int unsigned live_rings = 0;

  // rough copy of centers and radii, used only to aim shade pixels at ring bands
  int gen_x[erps_pkg::SLOTS], gen_y[erps_pkg::SLOTS], gen_rad[erps_pkg::SLOTS];
  int gen_slot = 0;
  int gen_count = 0;

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 100) $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic ring_table_step(input logic [1:0] op,
                                 input logic [erps_pkg::S_TDATA_W-1:0] d);
    int unsigned col, row, urow, dx, dy, sq_dist, lo, hi, a, b;
    int unsigned acc_r, acc_g, acc_b;
    case (op)
      erps_pkg::OP_SPAWN: begin
        ring_x[write_slot]   = d[6:0];
        ring_y[write_slot]   = d[13:7];
        ring_r[write_slot]   = d[21:14];
        ring_g[write_slot]   = d[29:22];
        ring_b[write_slot]   = d[37:30];
        ring_rad[write_slot] = 0;
        write_slot = (write_slot + 1 >= erps_pkg::SLOTS) ? 0 : write_slot + 1;
        if (live_rings < erps_pkg::SLOTS) live_rings++;
      end
      erps_pkg::OP_ADVANCE: begin
        for (int k = 0; k < live_rings; k++) begin
          if (ring_rad[k] < erps_pkg::RADIUS_MAX) ring_rad[k]++;
          ring_r[k] = ring_r[k] * 49 / 50;
          ring_g[k] = ring_g[k] * 49 / 50;
          ring_b[k] = ring_b[k] * 49 / 50;
        end
      end
      erps_pkg::OP_SHADE: begin
        col = d[44:38];
        row = d[49:45];
        acc_r = 0;
        acc_g = 0;
        acc_b = 0;
        for (int k = 0; k < live_rings; k++) begin
          if (ring_rad[k] < 6) begin
            lo = 0;
            hi = ring_rad[k] * ring_rad[k];
          end else begin
            a  = ring_rad[k] - ring_rad[k] / 6;
            b  = ring_rad[k] + ring_rad[k] / 6;
            lo = a * a;
            hi = b * b;
          end
          for (int f = 0; f < erps_pkg::FOLDS; f++) begin
            urow = row + f * erps_pkg::ROWS;
            dx = (ring_x[k] > col) ? ring_x[k] - col : col - ring_x[k];
            dy = (ring_y[k] > urow) ? ring_y[k] - urow : urow - ring_y[k];
            sq_dist = dx * dx + dy * dy;
            if (sq_dist >= lo && sq_dist <= hi) begin
              acc_r = (acc_r + ring_r[k] > erps_pkg::COLOR_MAX) ?
                      erps_pkg::COLOR_MAX : acc_r + ring_r[k];
              acc_g = (acc_g + ring_g[k] > erps_pkg::COLOR_MAX) ?
                      erps_pkg::COLOR_MAX : acc_g + ring_g[k];
              acc_b = (acc_b + ring_b[k] > erps_pkg::COLOR_MAX) ?
                      erps_pkg::COLOR_MAX : acc_b + ring_b[k];
            end
          end
        end
        expected_rgb_q.push_back({acc_b[7:0], acc_g[7:0], acc_r[7:0]});
      end
      default: ;  // unused op: nothing changes, nothing comes out
    endcase
  endtask

  // a field given as -1 is drawn at random over its full width
  task automatic queue_beat(input logic [1:0] op, input int x, input int y, input int r,
                            input int g, input int b, input int col, input int row);
    beat_t beat;
    if (x < 0)   x   = $urandom_range(0, 127);
    if (y < 0)   y   = $urandom_range(0, 127);
    if (r < 0)   r   = $urandom_range(0, 255);
    if (g < 0)   g   = $urandom_range(0, 255);
    if (b < 0)   b   = $urandom_range(0, 255);
    if (col < 0) col = $urandom_range(0, 127);
    if (row < 0) row = $urandom_range(0, 31);
    beat.op   = op;
    beat.data = {6'b0, 5'(row), 7'(col), 8'(b), 8'(g), 8'(r), 7'(y), 7'(x)};
    if (op == erps_pkg::OP_SPAWN) begin
      gen_x[gen_slot]   = x;
      gen_y[gen_slot]   = y;
      gen_rad[gen_slot] = 0;
      gen_slot = (gen_slot + 1) % erps_pkg::SLOTS;
      if (gen_count < erps_pkg::SLOTS) gen_count++;
    end else if (op == erps_pkg::OP_ADVANCE) begin
      for (int k = 0; k < gen_count; k++)
        if (gen_rad[k] < erps_pkg::RADIUS_MAX) gen_rad[k]++;
    end
    pending_beats.push_back(beat);
  endtask

  // frames of spawn / advance / a batch of shades, mostly aimed at ring bands
  task automatic run_frames(input int n_items);
    int done_items, n_shade, k, rad, t, dx, dy, col, urow, row;
    done_items = 0;
    while (done_items < n_items) begin
      if ((gen_count < erps_pkg::SLOTS && $urandom_range(0, 99) < 40) ||
          $urandom_range(0, 99) < 6) begin
        if ($urandom_range(0, 3) == 0)
          queue_beat(erps_pkg::OP_SPAWN, -1, -1, 255, -1, 255, -1, -1);
        else
          queue_beat(erps_pkg::OP_SPAWN, $urandom_range(0, 119), $urandom_range(0, 124),
                     -1, -1, -1, -1, -1);
        done_items++;
      end
      if ($urandom_range(0, 99) < 85) begin
        queue_beat(erps_pkg::OP_ADVANCE, -1, -1, -1, -1, -1, -1, -1);
        done_items++;
      end
      if ($urandom_range(0, 99) < 3) queue_beat(OP_UNUSED, -1, -1, -1, -1, -1, -1, -1);
      n_shade = $urandom_range(1, 8);
      repeat (n_shade) begin
        col  = -1;
        urow = -1;
        if (gen_count > 0 && $urandom_range(0, 9) < 7) begin
          k   = $urandom_range(0, gen_count - 1);
          rad = gen_rad[k];
          t   = (rad < 6) ? $urandom_range(0, rad)
                          : $urandom_range(rad - rad / 6 - 1, rad + rad / 6 + 1);
          dx  = $urandom_range(0, t);
          dy  = int'($sqrt(real'(t * t - dx * dx)));
          if ($urandom_range(0, 1) == 1) dx = -dx;
          if ($urandom_range(0, 1) == 1) dy = -dy;
          col  = gen_x[k] + dx;
          urow = gen_y[k] + dy;
        end
        if (col >= 0 && col <= 127 && urow >= 0 && urow <= 131) begin
          row = (urow >= 125) ? urow - 100 : urow % 25;
        end else begin
          col = -1;
          row = -1;
        end
        queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, col, row);
        done_items++;
      end
    end
  endtask

  // input driver: predict each beat as it is taken, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) ring_table_step(s_axis_tuser, s_axis_tdata);
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        next_beat = pending_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_beat.data;
        s_axis_tuser  <= next_beat.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, armed once
  always @(posedge clk) begin
    if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rgb_q.size() == 0) begin
          note_mismatch($sformatf("pixel beat %h with nothing expected", m_axis_tdata));
        end else begin
          pixel_want = expected_rgb_q.pop_front();
          for (int c = 0; c < 3; c++)
            if (m_axis_tdata[8*c +: 8] !== pixel_want[8*c +: 8])
              note_mismatch($sformatf("pixel %0d %s: got %0d, want %0d", pixels_seen,
                                      chan_name[c], m_axis_tdata[8*c +: 8],
                                      pixel_want[8*c +: 8]));
        end
        pixels_seen++;
      end
      m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty table, advance with no rings, unused op
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 0, 0);
    queue_beat(erps_pkg::OP_ADVANCE, -1, -1, -1, -1, -1, -1, -1);
    queue_beat(OP_UNUSED, -1, -1, -1, -1, -1, -1, -1);
    // radius-zero ring lights only its center
    queue_beat(erps_pkg::OP_SPAWN, 0, 0, 255, 255, 255, -1, -1);
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 0, 0);
    // out-of-range center, hit on the last fold, and the widest row code
    queue_beat(erps_pkg::OP_SPAWN, 127, 127, 1, 128, 254, -1, -1);
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 127, 27);
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 127, 31);
    // two rings on one center saturate red and green
    queue_beat(erps_pkg::OP_SPAWN, 60, 50, 200, 200, 200, -1, -1);
    queue_beat(erps_pkg::OP_SPAWN, 60, 50, 200, 100, 0, -1, -1);
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 60, 0);
    // radius 6: band runs from 25 to 49
    repeat (6) queue_beat(erps_pkg::OP_ADVANCE, -1, -1, -1, -1, -1, -1, -1);
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 64, 0);
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 65, 0);
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 67, 0);
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 68, 0);
    queue_beat(erps_pkg::OP_SHADE, -1, -1, -1, -1, -1, 119, 24);
    while (pending_beats.size() != 0 || s_axis_tvalid) @(negedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      idle_pct  <= IDLE_PCT[ph];
      stall_pct <= STALL_PCT[ph];
      // hold the output while the sender keeps pushing, so the input backs up
      if (ph == 0) hold_go <= 1'b1;
      run_frames(PHASE_ITEMS);
      while (pending_beats.size() != 0 || s_axis_tvalid) @(negedge clk);
    end

    for (int w = 0; w < RESULT_WAIT && expected_rgb_q.size() != 0; w++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_rgb_q.size() != 0)
      note_mismatch($sformatf("%0d pixels never came out", expected_rgb_q.size()));

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/erps_pkg.sv
rtl/expanding_ring_pixel_shader.sv
rtl/erps_checker.sv
test/expanding_ring_pixel_shader_test.sv
